>>> hw/rtl/torsion_histogram_reliability_map_defines.svh
// Assertion macros shared by the torsion histogram reliability map RTL.
// Depends on nothing; a module that uses them must have clk and rst_n in scope.
`ifndef TORSION_HISTOGRAM_RELIABILITY_MAP_DEFINES_SVH
`define TORSION_HISTOGRAM_RELIABILITY_MAP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define THRM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define THRM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/thrm_pkg.sv
// Shared constants, types and helper functions of the torsion histogram reliability map.
// Depends on nothing; thrm_ctrl, thrm_eval and the top level import it.
package thrm_pkg;

    localparam int ANGLE_BINS    = 32;
    localparam int RESIDUE_TYPES = 32;
    localparam int COUNT_WIDTH   = 16;

    localparam int IN_W      = 5;
    localparam int CMD_W     = 2;
    localparam int CLASS_W   = 2;
    localparam int OUT_CNT_W = 16;
    localparam int THR_W     = 16;
    localparam int IDX_CMP_W = 10;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(5);

    localparam int BIN_W   = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1;
    localparam int RES_W   = (RESIDUE_TYPES > 1) ? $clog2(RESIDUE_TYPES) : 1;
    localparam int ADDR_W  = RES_W + 2 * BIN_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int CMP_W   = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
    localparam int SAT_W   = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CLASS_W-1:0] CLASS_SPARSE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_NEAR     = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_RELIABLE = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // Travels with each query memory read so the evaluator knows what the data is.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic blank;
    } rd_tag_t;

    function automatic logic count_above(input count_t cnt, input logic [THR_W-1:0] thr);
        return CMP_W'(cnt) > CMP_W'(thr);
    endfunction

    function automatic logic [OUT_CNT_W-1:0] count_sat(input count_t cnt);
        logic [SAT_W-1:0] ext;
        ext = SAT_W'(cnt);
        if (ext > SAT_W'({OUT_CNT_W{1'b1}}))
            return {OUT_CNT_W{1'b1}};
        else
            return ext[OUT_CNT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/thrm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module thrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/thrm_ctrl.sv
// Sequencer of the count table: accepts items, runs clear sweeps, read-modify-write adds
// and the nine-read query walk. Depends on thrm_pkg and the defines header.
`include "torsion_histogram_reliability_map_defines.svh"

module thrm_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [thrm_pkg::CMD_W-1:0]   cmd,
    input  logic [thrm_pkg::IN_W-1:0]    residue_type,
    input  logic [thrm_pkg::IN_W-1:0]    phi_bin,
    input  logic [thrm_pkg::IN_W-1:0]    psi_bin,
    output logic                         rd_en,
    output logic [thrm_pkg::ADDR_W-1:0]  rd_addr,
    input  thrm_pkg::count_t             rd_data,
    output logic                         wr_en,
    output logic [thrm_pkg::ADDR_W-1:0]  wr_addr,
    output thrm_pkg::count_t             wr_data,
    output thrm_pkg::rd_tag_t            tag
);
    import thrm_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ADD_RD = 3'd2;
    localparam logic [2:0] ST_ADD_WR = 3'd3;
    localparam logic [2:0] ST_QUERY  = 3'd4;

    localparam logic [3:0] STEP_LAST = 4'd8;

    localparam logic [1:0] OFF_MID = 2'd0;
    localparam logic [1:0] OFF_DEC = 2'd1;
    localparam logic [1:0] OFF_INC = 2'd2;

    logic [2:0]        state_reg, state_next;
    logic [3:0]        step_reg, step_next;
    logic [ADDR_W-1:0] clr_ptr_reg, clr_ptr_next;
    rd_tag_t           tag_reg, tag_next;
    logic [RES_W-1:0]  res_reg;
    logic [BIN_W-1:0]  phi_reg, psi_reg;

    logic              accept;
    logic              in_ok;
    logic [3:0]        offs;
    logic [ADDR_W-1:0] cell_addr;
    logic [ADDR_W-1:0] nbr_addr;

    function automatic logic [3:0] step_offsets(input logic [3:0] step);
        logic [3:0] r;
        case (step)
            4'd1:    r = {OFF_MID, OFF_DEC};
            4'd2:    r = {OFF_MID, OFF_INC};
            4'd3:    r = {OFF_DEC, OFF_MID};
            4'd4:    r = {OFF_DEC, OFF_DEC};
            4'd5:    r = {OFF_DEC, OFF_INC};
            4'd6:    r = {OFF_INC, OFF_MID};
            4'd7:    r = {OFF_INC, OFF_DEC};
            4'd8:    r = {OFF_INC, OFF_INC};
            default: r = {OFF_MID, OFF_MID};
        endcase
        return r;
    endfunction

    // Step one bin down or up, or stay put, with wrap-around on the angle axis.
    function automatic logic [BIN_W-1:0] bin_move(input logic [BIN_W-1:0] x,
                                                  input logic [1:0] off);
        logic [BIN_W-1:0] r;
        case (off)
            OFF_DEC: r = (x == '0) ? BIN_W'(ANGLE_BINS - 1) : x - 1'b1;
            OFF_INC: r = (x == BIN_W'(ANGLE_BINS - 1)) ? '0 : x + 1'b1;
            default: r = x;
        endcase
        return r;
    endfunction

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign in_ok  = ({{(IDX_CMP_W-IN_W){1'b0}}, residue_type} < IDX_CMP_W'(RESIDUE_TYPES))
                 && ({{(IDX_CMP_W-IN_W){1'b0}}, phi_bin} < IDX_CMP_W'(ANGLE_BINS))
                 && ({{(IDX_CMP_W-IN_W){1'b0}}, psi_bin} < IDX_CMP_W'(ANGLE_BINS));

    assign offs      = step_offsets(step_reg);
    assign cell_addr = {res_reg, phi_reg, psi_reg};
    assign nbr_addr  = {res_reg, bin_move(phi_reg, offs[3:2]), bin_move(psi_reg, offs[1:0])};

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        clr_ptr_next = clr_ptr_reg;
        tag_next     = '0;
        rd_en        = 1'b0;
        rd_addr      = cell_addr;
        wr_en        = 1'b0;
        wr_addr      = cell_addr;
        wr_data      = (rd_data == '1) ? rd_data : rd_data + 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_ptr_reg;
                wr_data = '0;
                if (clr_ptr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
                clr_ptr_next = clr_ptr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_ADD:
                        begin
                            if (in_ok)
                            begin
                                state_next = ST_ADD_RD;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (in_ok)
                            begin
                                state_next = ST_QUERY;
                                step_next  = '0;
                            end
                            else
                            begin
                                tag_next = '{valid: 1'b1, first: 1'b1, last: 1'b1, blank: 1'b1};
                            end
                        end
                        CMD_CLEAR:
                        begin
                            state_next   = ST_CLEAR;
                            clr_ptr_next = '0;
                        end
                        default:
                        begin
                            // drop the unused command
                        end
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                wr_en      = 1'b1;
                state_next = ST_IDLE;
            end
            ST_QUERY:
            begin
                rd_en    = 1'b1;
                rd_addr  = nbr_addr;
                tag_next = '{valid: 1'b1, first: (step_reg == '0),
                             last: (step_reg == STEP_LAST), blank: 1'b0};
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            step_reg    <= '0;
            clr_ptr_reg <= '0;
            tag_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            clr_ptr_reg <= clr_ptr_next;
            tag_reg     <= tag_next;
        end
    end

    // Hold the item's cell coordinates for the whole operation.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= RES_W'(residue_type);
            phi_reg <= BIN_W'(phi_bin);
            psi_reg <= BIN_W'(psi_bin);
        end
    end

    assign tag = tag_reg;

    `THRM_ASSERT_IMP(a_no_rd_wr_overlap, rd_en, !wr_en, "read and write in the same cycle")
    `THRM_ASSERT_NXT(a_add_rmw, state_reg == ST_ADD_RD, wr_en && (state_reg == ST_ADD_WR),
                     "add read not followed by its write-back")
    `THRM_ASSERT_IMP(a_last_is_ninth, tag_next.last && !tag_next.blank,
                     step_reg == STEP_LAST, "query walk ended before the ninth cell")

endmodule

>>> hw/rtl/thrm_eval.sv
// Query evaluator: compares the streamed cell counts with the threshold and forms the
// class and saturated count of each query. Depends on thrm_pkg and the defines header.
`include "torsion_histogram_reliability_map_defines.svh"

module thrm_eval (
    input  logic                            clk,
    input  logic                            rst_n,
    input  thrm_pkg::rd_tag_t               tag,
    input  thrm_pkg::count_t                rd_data,
    input  logic [thrm_pkg::THR_W-1:0]      threshold,
    output logic                            result_valid,
    output logic [thrm_pkg::CLASS_W-1:0]    bin_class,
    output logic [thrm_pkg::OUT_CNT_W-1:0]  centre_count
);
    import thrm_pkg::*;

    logic                 result_valid_reg;
    logic [CLASS_W-1:0]   bin_class_reg, bin_class_next;
    logic [OUT_CNT_W-1:0] centre_count_reg, centre_count_next;
    count_t               centre_cnt_reg;
    logic                 centre_hit_reg;
    logic                 nbr_hit_reg;
    logic                 hit;

    assign hit = count_above(rd_data, threshold);

    always_comb
    begin
        if (tag.blank)
        begin
            bin_class_next    = CLASS_SPARSE;
            centre_count_next = '0;
        end
        else
        begin
            centre_count_next = count_sat(centre_cnt_reg);
            if (centre_hit_reg)
                bin_class_next = CLASS_RELIABLE;
            else if (nbr_hit_reg || hit)
                bin_class_next = CLASS_NEAR;
            else
                bin_class_next = CLASS_SPARSE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= tag.valid && tag.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag.valid)
        begin
            if (tag.first)
            begin
                centre_cnt_reg <= rd_data;
                centre_hit_reg <= hit;
                nbr_hit_reg    <= 1'b0;
            end
            else
            begin
                nbr_hit_reg <= nbr_hit_reg || hit;
            end
            if (tag.last)
            begin
                bin_class_reg    <= bin_class_next;
                centre_count_reg <= centre_count_next;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign bin_class    = bin_class_reg;
    assign centre_count = centre_count_reg;

    `THRM_ASSERT_IMP(a_walk_contiguous, tag.valid && !tag.first, $past(tag.valid),
                     "gap inside a query read stream")
    `THRM_ASSERT_IMP(a_walk_nine, tag.valid && tag.last && !tag.blank,
                     $past(tag.valid, 8) && $past(tag.first, 8),
                     "query stream is not nine reads long")

endmodule

>>> hw/rtl/torsion_histogram_reliability_map.sv
// Top level of the torsion histogram reliability map: threshold register, count table RAM,
// sequencer and query evaluator. Depends on thrm_pkg, thrm_ram, thrm_ctrl and thrm_eval.

// Items are taken when start is high and busy is low. All counts sit in one RAM with a
// single read port, which sets the timing: an add is a read-modify-write, a read state
// and then a write-back state, after which the block is free; a query reads its cell and
// the eight wrapped neighbours one per cycle, frees the block after the last read and
// strobes result_valid for one cycle right after that; a query with an out-of-range index
// answers sparse with count zero without touching the RAM. A clear, and likewise reset,
// sweeps every RAM entry one per cycle (32768 entries at the default sizes) with busy
// high. The result is shown for one cycle only, so the receiver must take it then. Write
// the threshold only while no item is in flight.
module torsion_histogram_reliability_map (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [thrm_pkg::CMD_W-1:0]      cmd,
    input  logic [thrm_pkg::IN_W-1:0]       residue_type,
    input  logic [thrm_pkg::IN_W-1:0]       phi_bin,
    input  logic [thrm_pkg::IN_W-1:0]       psi_bin,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [thrm_pkg::THR_W-1:0]      cfg_threshold,
    output logic                            result_valid,
    output logic [thrm_pkg::CLASS_W-1:0]    bin_class,
    output logic [thrm_pkg::OUT_CNT_W-1:0]  centre_count
);
    import thrm_pkg::*;

    logic [THR_W-1:0]  threshold_reg;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    count_t            rd_data;
    count_t            wr_data;
    rd_tag_t           tag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_threshold;
        end
    end

    thrm_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_counts (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    thrm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .residue_type (residue_type),
        .phi_bin      (phi_bin),
        .psi_bin      (psi_bin),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .tag          (tag)
    );

    thrm_eval u_eval (
        .clk          (clk),
        .rst_n        (rst_n),
        .tag          (tag),
        .rd_data      (rd_data),
        .threshold    (threshold_reg),
        .result_valid (result_valid),
        .bin_class    (bin_class),
        .centre_count (centre_count)
    );

endmodule
